// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL that carries checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/m8alu_pkg.sv =====
// Shared types and codes for the 8-bit ALU with status flags.
// No dependencies.
package m8alu_pkg;

    // Operation codes
    typedef enum logic [4:0] {
        ACT_ADD   = 5'd0,
        ACT_ADC   = 5'd1,
        ACT_SUB   = 5'd2,
        ACT_SBC   = 5'd3,
        ACT_CP    = 5'd4,
        ACT_CPC   = 5'd5,
        ACT_AND   = 5'd6,
        ACT_OR    = 5'd7,
        ACT_EOR   = 5'd8,
        ACT_COM   = 5'd9,
        ACT_NEG   = 5'd10,
        ACT_INC   = 5'd11,
        ACT_DEC   = 5'd12,
        ACT_LSR   = 5'd13,
        ACT_ASR   = 5'd14,
        ACT_ROR   = 5'd15,
        ACT_SWAP  = 5'd16,
        ACT_ADIW  = 5'd17,
        ACT_SBIW  = 5'd18,
        ACT_MUL   = 5'd19,
        ACT_MULS  = 5'd20,
        ACT_MULSU = 5'd21,
        ACT_FMUL  = 5'd22,
        ACT_BST   = 5'd23,
        ACT_BLD   = 5'd24,
        ACT_MOV   = 5'd25
    } t_action;

    // Status byte bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_V = 3;
    localparam int unsigned FLAG_S = 4;
    localparam int unsigned FLAG_H = 5;
    localparam int unsigned FLAG_T = 6;
    localparam int unsigned FLAG_I = 7;

    // Input beat
    typedef struct packed {
        logic [4:0]  action;
        logic [15:0] operand_a;
        logic [7:0]  operand_b;
        logic [2:0]  bit_select;
        logic [7:0]  status_in;
    } t_alu_in;

    // Result beat
    typedef struct packed {
        logic [15:0] result;
        logic [7:0]  status_out;
        logic        write_back;
        logic        result_is_word;
    } t_alu_out;

endpackage

// ===== rtl/core/m8alu_exec.sv =====
// Single-pass ALU datapath: result, status byte and write controls.
// Depends on m8alu_pkg.
module m8alu_exec (
    input  m8alu_pkg::t_alu_in  i_cmd,
    output m8alu_pkg::t_alu_out o_rsp
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [8:0]  mul_a;
    logic [8:0]  mul_b;
    logic [17:0] prod;
    logic        a_signed;
    logic        b_signed;

    assign a   = i_cmd.operand_a[7:0];
    assign b   = i_cmd.operand_b;
    assign cin = i_cmd.status_in[m8alu_pkg::FLAG_C];

    // Share one signed 9x9 multiplier across the four multiply forms
    assign a_signed = (i_cmd.action == m8alu_pkg::ACT_MULS)
                   || (i_cmd.action == m8alu_pkg::ACT_MULSU);
    assign b_signed = (i_cmd.action == m8alu_pkg::ACT_MULS);
    assign mul_a    = {a_signed & a[7], a};
    assign mul_b    = {b_signed & b[7], b};
    assign prod     = 18'($signed(mul_a) * $signed(mul_b));

    // Rebuild N, Z, V, S from a byte result
    function automatic logic [7:0] nzvs8(input logic [7:0] st, input logic [7:0] r,
                                         input logic v);
        logic [7:0] s;
        begin
            s = st;
            s[m8alu_pkg::FLAG_N] = r[7];
            s[m8alu_pkg::FLAG_Z] = (r == 8'h00);
            s[m8alu_pkg::FLAG_V] = v;
            s[m8alu_pkg::FLAG_S] = r[7] ^ v;
            return s;
        end
    endfunction

    // Decode and evaluate the operation
    always_comb begin
        logic [7:0]  r8;
        logic [15:0] r16;
        logic [7:0]  st;
        logic [7:0]  cy;
        logic [7:0]  mask;
        logic        v;
        logic        carry_in;
        logic        wb;
        logic        word;

        r8       = 8'h00;
        r16      = 16'h0000;
        st       = i_cmd.status_in;
        cy       = 8'h00;
        v        = 1'b0;
        wb       = 1'b1;
        word     = 1'b0;
        mask     = 8'h01 << i_cmd.bit_select;
        carry_in = cin && ((i_cmd.action == m8alu_pkg::ACT_ADC)
                        || (i_cmd.action == m8alu_pkg::ACT_SBC)
                        || (i_cmd.action == m8alu_pkg::ACT_CPC));

        case (i_cmd.action)
            m8alu_pkg::ACT_ADD, m8alu_pkg::ACT_ADC: begin
                r8 = a + b + {7'd0, carry_in};
                cy = (a & b) | (b & ~r8) | (~r8 & a);
                v  = (a[7] & b[7] & ~r8[7]) | (~a[7] & ~b[7] & r8[7]);
                st = nzvs8(st, r8, v);
                st[m8alu_pkg::FLAG_C] = cy[7];
                st[m8alu_pkg::FLAG_H] = cy[3];
            end
            m8alu_pkg::ACT_SUB, m8alu_pkg::ACT_CP,
            m8alu_pkg::ACT_SBC, m8alu_pkg::ACT_CPC: begin
                r8 = a - b - {7'd0, carry_in};
                cy = (~a & b) | (b & r8) | (r8 & ~a);
                v  = (a[7] & ~b[7] & ~r8[7]) | (~a[7] & b[7] & r8[7]);
                st = nzvs8(st, r8, v);
                st[m8alu_pkg::FLAG_C] = cy[7];
                st[m8alu_pkg::FLAG_H] = cy[3];
                // Carry forms keep Z only if it was already set
                if ((i_cmd.action == m8alu_pkg::ACT_SBC)
                    || (i_cmd.action == m8alu_pkg::ACT_CPC)) begin
                    st[m8alu_pkg::FLAG_Z] = st[m8alu_pkg::FLAG_Z]
                                          & i_cmd.status_in[m8alu_pkg::FLAG_Z];
                end
                wb = (i_cmd.action != m8alu_pkg::ACT_CP)
                  && (i_cmd.action != m8alu_pkg::ACT_CPC);
            end
            m8alu_pkg::ACT_AND: begin
                r8 = a & b;
                st = nzvs8(st, r8, 1'b0);
            end
            m8alu_pkg::ACT_OR: begin
                r8 = a | b;
                st = nzvs8(st, r8, 1'b0);
            end
            m8alu_pkg::ACT_EOR: begin
                r8 = a ^ b;
                st = nzvs8(st, r8, 1'b0);
            end
            m8alu_pkg::ACT_COM: begin
                r8 = ~a;
                st = nzvs8(st, r8, 1'b0);
                st[m8alu_pkg::FLAG_C] = 1'b1;
            end
            m8alu_pkg::ACT_NEG: begin
                r8 = 8'h00 - a;
                st = nzvs8(st, r8, r8 == 8'h80);
                st[m8alu_pkg::FLAG_C] = (r8 != 8'h00);
                st[m8alu_pkg::FLAG_H] = r8[3] | a[3];
            end
            m8alu_pkg::ACT_INC: begin
                r8 = a + 8'h01;
                st = nzvs8(st, r8, r8 == 8'h80);
            end
            m8alu_pkg::ACT_DEC: begin
                r8 = a - 8'h01;
                st = nzvs8(st, r8, r8 == 8'h7F);
            end
            m8alu_pkg::ACT_LSR, m8alu_pkg::ACT_ASR, m8alu_pkg::ACT_ROR: begin
                // Top bit: zero, sign, or incoming carry
                if (i_cmd.action == m8alu_pkg::ACT_LSR) begin
                    r8 = {1'b0, a[7:1]};
                end else if (i_cmd.action == m8alu_pkg::ACT_ASR) begin
                    r8 = {a[7], a[7:1]};
                end else begin
                    r8 = {cin, a[7:1]};
                end
                st = nzvs8(st, r8, r8[7] ^ a[0]);
                st[m8alu_pkg::FLAG_C] = a[0];
            end
            m8alu_pkg::ACT_SWAP: begin
                r8 = {a[3:0], a[7:4]};
            end
            m8alu_pkg::ACT_ADIW, m8alu_pkg::ACT_SBIW: begin
                word = 1'b1;
                if (i_cmd.action == m8alu_pkg::ACT_ADIW) begin
                    r16 = i_cmd.operand_a + {8'h00, b};
                    v   = ~i_cmd.operand_a[15] & r16[15];
                    st[m8alu_pkg::FLAG_C] = i_cmd.operand_a[15] & ~r16[15];
                end else begin
                    r16 = i_cmd.operand_a - {8'h00, b};
                    v   = i_cmd.operand_a[15] & ~r16[15];
                    st[m8alu_pkg::FLAG_C] = ~i_cmd.operand_a[15] & r16[15];
                end
                st[m8alu_pkg::FLAG_Z] = (r16 == 16'h0000);
                st[m8alu_pkg::FLAG_N] = r16[15];
                st[m8alu_pkg::FLAG_V] = v;
                st[m8alu_pkg::FLAG_S] = r16[15] ^ v;
            end
            m8alu_pkg::ACT_MUL, m8alu_pkg::ACT_MULS, m8alu_pkg::ACT_MULSU: begin
                word = 1'b1;
                r16  = prod[15:0];
                st[m8alu_pkg::FLAG_C] = r16[15];
                st[m8alu_pkg::FLAG_Z] = (r16 == 16'h0000);
            end
            m8alu_pkg::ACT_FMUL: begin
                // Carry comes from the product before the shift
                word = 1'b1;
                r16  = {prod[14:0], 1'b0};
                st[m8alu_pkg::FLAG_C] = prod[15];
                st[m8alu_pkg::FLAG_Z] = (r16 == 16'h0000);
            end
            m8alu_pkg::ACT_BST: begin
                st[m8alu_pkg::FLAG_T] = a[i_cmd.bit_select];
                wb = 1'b0;
            end
            m8alu_pkg::ACT_BLD: begin
                r8 = i_cmd.status_in[m8alu_pkg::FLAG_T] ? (a | mask) : (a & ~mask);
            end
            m8alu_pkg::ACT_MOV: begin
                r8 = b;
            end
            default: begin
                wb = 1'b0;
            end
        endcase

        o_rsp.result         = word ? r16 : {8'h00, r8};
        o_rsp.status_out     = st;
        o_rsp.write_back     = wb;
        o_rsp.result_is_word = word;
    end

endmodule

// ===== rtl/core/mcu8_alu_with_status_flags.sv =====
// Top level of the 8-bit ALU with status flags: input and result registers.
// Depends on m8alu_pkg, m8alu_exec and assert_macros.svh.
//
// Usage:
//   Command channel: drive i_cmd and raise start; the beat is taken at the
//   rising edge where start is high and busy is low. busy is low whenever
//   reset is released, so a new command may be issued every cycle.
//   Result channel: o_done is high for exactly one cycle with o_rsp valid;
//   the receiver takes it at the edge that ends that cycle and cannot stall.
//   Path: an accepted beat passes through the input register, one pass of
//   ALU logic and the result register before the receiver takes the result.
//   Throughput: 1 command per cycle, set by the single ALU pass between the
//   two registers; the slowest path is the 9x9 multiplier.
//   Reset: synchronous, active low; clears both valid bits, so any command
//   in flight is dropped and no result appears until a new start. busy is
//   high while reset is asserted.
`include "assert_macros.svh"

module mcu8_alu_with_status_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  m8alu_pkg::t_alu_in  i_cmd,
    output logic                o_done,
    output m8alu_pkg::t_alu_out o_rsp
);

    m8alu_pkg::t_alu_in  r_in;
    m8alu_pkg::t_alu_in  n_in;
    logic                r_in_vld;
    logic                n_in_vld;
    m8alu_pkg::t_alu_out r_out;
    m8alu_pkg::t_alu_out n_out;
    logic                r_done;
    logic                n_done;
    m8alu_pkg::t_alu_out exec_rsp;

    // Accept a beat every cycle outside reset
    assign busy = ~i_rst_n;

    // Advance the two stages
    always_comb begin
        n_in_vld = start & ~busy;
        n_in     = i_cmd;
        n_done   = r_in_vld;
        n_out    = exec_rsp;
    end

    m8alu_exec u_exec (
        .i_cmd (r_in),
        .o_rsp (exec_rsp)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
            r_done   <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_rsp  = r_out;

    // Checks
    `ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, start && !busy, r_in_vld)
    `ASSERT_NEXT(a_stage_to_done, i_clk, i_rst_n, r_in_vld, o_done)
    `ASSERT_SAME(a_word_writes, i_clk, i_rst_n, o_done && o_rsp.result_is_word, o_rsp.write_back)
    `ASSERT_SAME(a_i_flag_kept, i_clk, i_rst_n, o_done, o_rsp.status_out[7] == $past(r_in.status_in[7]))

endmodule
